// ----- design/running_variance_accumulator_defines.svh -----
// Assertion macros shared by the running variance accumulator modules.
`ifndef RUNNING_VARIANCE_ACCUMULATOR_DEFINES_SVH
`define RUNNING_VARIANCE_ACCUMULATOR_DEFINES_SVH

// Implication checked on every rising clock edge outside reset.
`define RVA_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication checked on every rising clock edge outside reset.
`define RVA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- design/rva_pkg.sv -----
// Package with widths, codes and command types of the running variance accumulator.
package rva_pkg;
  localparam int COUNT_BITS  = 16;
  localparam int SAMPLE_BITS = 16;
  localparam int SQ_BITS     = 46;
  localparam int SUM_BITS    = 32;
  localparam int NUM_BITS    = 62;
  localparam int DEN_BITS    = 2 * COUNT_BITS;
  localparam int VAR_BITS    = 31;
  localparam int SD_BITS     = 16;
  localparam int MUL_BITS    = 64;
  localparam int IN_DATA_W   = 24;
  localparam int OUT_DATA_W  = 104;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [VAR_BITS-1:0]   VAR_MAX   = {VAR_BITS{1'b1}};

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // take the request and update the accumulators
    logic mul_a;     // product count * square sum
    logic mul_b;     // product |sum| * |sum|
    logic mul_n;     // product count * count, start division
    logic div_step;  // one restoring division step
    logic sqrt_init; // set up the square root
    logic sqrt_step; // one square root step
    logic out_load;  // copy results to the output register
  } rva_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_done;
    logic sqrt_done;
  } rva_stat_t;
endpackage

// ----- design/rva_ctrl.sv -----
// Controller state machine sequencing the running variance datapath.
`include "running_variance_accumulator_defines.svh"
module rva_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output rva_pkg::rva_cmd_t  cmd_o,
  input  rva_pkg::rva_stat_t stat_i
);
  import rva_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MA   = 3'd1;
  localparam logic [2:0] S_MB   = 3'd2;
  localparam logic [2:0] S_MN   = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_SQI  = 3'd5;
  localparam logic [2:0] S_SQ   = 3'd6;
  localparam logic [2:0] S_OUT  = 3'd7;

  logic [2:0] state_q, state_d;
  logic       ovalid_q, ovalid_d;

  // The output register may be loaded when empty or drained this cycle.
  logic out_free;
  assign out_free = !ovalid_q || out_ready_i;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = ovalid_q;

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    ovalid_d = ovalid_q && !out_ready_i;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = S_MA;
        end
      end
      S_MA: begin
        cmd_o.mul_a = 1'b1;
        state_d = S_MB;
      end
      S_MB: begin
        cmd_o.mul_b = 1'b1;
        state_d = S_MN;
      end
      S_MN: begin
        cmd_o.mul_n = 1'b1;
        state_d = S_DIV;
      end
      S_DIV: begin
        if (stat_i.div_done) begin
          state_d = S_SQI;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      S_SQI: begin
        cmd_o.sqrt_init = 1'b1;
        state_d = S_SQ;
      end
      S_SQ: begin
        if (stat_i.sqrt_done) begin
          state_d = S_OUT;
        end else begin
          cmd_o.sqrt_step = 1'b1;
        end
      end
      S_OUT: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          ovalid_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
    end
  end

  `RVA_ASSERT_IMPL(a_load_idle, cmd_o.load, state_q == S_IDLE)
  `RVA_ASSERT_NEXT(a_out_valid, cmd_o.out_load, out_valid_o)
  `RVA_ASSERT_IMPL(a_no_overwrite, cmd_o.out_load, out_free)
endmodule

// ----- design/rva_datapath.sv -----
// Datapath: accumulators, shared multiplier, restoring divider and square root.
`include "running_variance_accumulator_defines.svh"
module rva_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          opcode_i,
  input  logic [rva_pkg::SAMPLE_BITS-1:0] sample_i,
  input  rva_pkg::rva_cmd_t             cmd_i,
  output rva_pkg::rva_stat_t            stat_o,
  output logic [rva_pkg::OUT_DATA_W-1:0] out_data_o
);
  import rva_pkg::*;

  logic [COUNT_BITS-1:0] cnt_q;
  logic [SUM_BITS-1:0]   sum_q;
  logic [SQ_BITS-1:0]    sq_q;
  logic [1:0]            status_q;

  // Sample extension and square.
  logic signed [SAMPLE_BITS-1:0] smp;
  logic [SUM_BITS-1:0]           smp_ext;
  logic [SQ_BITS-1:0]            smp_sq;
  assign smp     = $signed(sample_i);
  assign smp_ext = SUM_BITS'(smp);
  assign smp_sq  = SQ_BITS'($unsigned(32'(smp) * 32'(smp)));

  // Accumulator update on request.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      sum_q    <= '0;
      sq_q     <= '0;
      status_q <= ST_OK;
    end else if (cmd_i.load) begin
      status_q <= ST_OK;
      if (opcode_i) begin
        if (cnt_q == '0) begin
          status_q <= ST_EMPTY;
        end else begin
          cnt_q <= cnt_q - 1'b1;
          sum_q <= sum_q - smp_ext;
          sq_q  <= sq_q - smp_sq;
        end
      end else begin
        if (cnt_q == COUNT_MAX) begin
          status_q <= ST_FULL;
        end else begin
          cnt_q <= cnt_q + 1'b1;
          sum_q <= sum_q + smp_ext;
          sq_q  <= sq_q + smp_sq;
        end
      end
    end
  end

  // Shared multiplier, one product per cycle.
  logic [SUM_BITS-1:0] mag;
  logic [31:0]         mop_a, mop_b;
  logic [MUL_BITS-1:0] prod;
  logic [MUL_BITS-1:0] a_q;
  assign mag = sum_q[SUM_BITS-1] ? (~sum_q + 1'b1) : sum_q;
  always_comb begin
    mop_a = 32'(cnt_q);
    mop_b = 32'(cnt_q);
    if (cmd_i.mul_b) begin
      mop_a = mag;
      mop_b = mag;
    end
  end
  assign prod = MUL_BITS'(mop_a) * MUL_BITS'(mop_b);

  // The square-sum product is 62 bits: split into two 23-bit halves of sq.
  logic [MUL_BITS-1:0] pa_lo, pa_hi;
  assign pa_lo = MUL_BITS'(cnt_q) * MUL_BITS'(sq_q[22:0]);
  assign pa_hi = MUL_BITS'(cnt_q) * MUL_BITS'(sq_q[SQ_BITS-1:23]);

  // Division state: remainder, quotient, divisor, step count.
  logic [NUM_BITS:0]   rem_q;
  logic [NUM_BITS-1:0] num_q;
  logic [NUM_BITS-1:0] quo_q;
  logic [DEN_BITS-1:0] den_q;
  logic [5:0]          dcnt_q;
  logic                zero_q;
  logic [MUL_BITS-1:0] lo_q, hi_q;

  logic [NUM_BITS:0]   rem_sh, rem_sub;
  assign rem_sh  = {rem_q[NUM_BITS-1:0], num_q[NUM_BITS-1]};
  assign rem_sub = rem_sh - (NUM_BITS+1)'(den_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dcnt_q <= '0;
    end else if (cmd_i.mul_n) begin
      dcnt_q <= 6'(NUM_BITS);
    end else if (cmd_i.div_step) begin
      dcnt_q <= dcnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_a) begin
      lo_q <= pa_lo;
      hi_q <= pa_hi;
    end
    if (cmd_i.mul_b) begin
      a_q <= lo_q + (hi_q << 23);
      num_q <= '0;
    end
    if (cmd_i.mul_n) begin
      den_q  <= DEN_BITS'(prod);
      zero_q <= (cnt_q == '0) || (a_q <= lo_q);
      num_q  <= NUM_BITS'(a_q - lo_q);
      rem_q  <= '0;
      quo_q  <= '0;
    end
    if (cmd_i.mul_b) begin
      lo_q <= prod;
    end
    if (cmd_i.div_step) begin
      num_q <= num_q << 1;
      if (!rem_sub[NUM_BITS]) begin
        rem_q <= rem_sub;
        quo_q <= {quo_q[NUM_BITS-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh;
        quo_q <= {quo_q[NUM_BITS-2:0], 1'b0};
      end
    end
  end
  assign stat_o.div_done = (dcnt_q == '0);

  // Variance with zero and saturation cases.
  logic [VAR_BITS-1:0] var_w;
  always_comb begin
    if (zero_q) begin
      var_w = '0;
    end else if (quo_q > NUM_BITS'(VAR_MAX)) begin
      var_w = VAR_MAX;
    end else begin
      var_w = VAR_BITS'(quo_q);
    end
  end

  // Square root, two bits of the radicand per step.
  logic [31:0] sx_q, sres_q, sbit_q;
  logic [VAR_BITS-1:0] var_q;
  logic [32:0] strial;
  assign strial = 33'(sres_q) + 33'(sbit_q);
  always_ff @(posedge clk_i) begin
    if (cmd_i.sqrt_init) begin
      var_q  <= var_w;
      sx_q   <= 32'(var_w);
      sres_q <= '0;
      sbit_q <= 32'h4000_0000;
    end else if (cmd_i.sqrt_step) begin
      if (33'(sx_q) >= strial) begin
        sx_q   <= sx_q - strial[31:0];
        sres_q <= (sres_q >> 1) + sbit_q;
      end else begin
        sres_q <= sres_q >> 1;
      end
      sbit_q <= sbit_q >> 2;
    end
  end
  assign stat_o.sqrt_done = (sbit_q == '0);

  // Output register.
  logic [OUT_DATA_W-1:0] odata_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      odata_q <= {7'd0, status_q, sres_q[SD_BITS-1:0], var_q, sum_q, cnt_q};
    end
  end
  assign out_data_o = odata_q;

  `RVA_ASSERT_NEXT(a_div_start, cmd_i.mul_n, dcnt_q == 6'(NUM_BITS))
  `RVA_ASSERT_IMPL(a_sqrt_not_div, cmd_i.sqrt_step, !cmd_i.div_step)
  `RVA_ASSERT_IMPL(a_load_alone, cmd_i.load, !cmd_i.div_step && !cmd_i.sqrt_step)
endmodule

// ----- design/running_variance_accumulator.sv -----
// Top level of the running variance accumulator.
// Usage:
// Input requests arrive on s_axis: tdata[0] is the opcode (0 insert, 1 remove),
// tdata[16:1] the signed Q8.8 sample. Each accepted request yields one result
// on m_axis: count [15:0], sum [47:16], variance Q15.16 [78:48], standard
// deviation Q8.8 [94:79] and status [96:95].
// From the accepting edge to m_axis_tvalid a request passes the multiply
// states (count * square sum, |sum| * |sum|, count * count), the restoring
// divider (62 quotient bits and a done check), the square root setup, the
// square root (16 steps and a done check) and the output load. One request is
// in work at a time: s_axis_tready stays low until its result is loaded into
// the output register.
// The output register holds the result until m_axis_tready; the next request
// is taken while a result still waits, and its result waits in turn with
// s_axis_tready low until the output register drains.
// Reset clears the count, sum and square sum and drops m_axis_tvalid.
module running_variance_accumulator (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [rva_pkg::IN_DATA_W-1:0]   s_axis_tdata,  // opcode, sample_value
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [rva_pkg::OUT_DATA_W-1:0]  m_axis_tdata   // count, sum, var, sd, status
);
  import rva_pkg::*;

  rva_cmd_t  cmd;
  rva_stat_t stat;

  rva_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  rva_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .opcode_i   (s_axis_tdata[0]),
    .sample_i   (s_axis_tdata[SAMPLE_BITS:1]),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .out_data_o (m_axis_tdata)
  );
endmodule
